[hdl/fir4_pkg.sv]
`timescale 1ns / 1ps

package fir4_pkg;

    localparam int TAPS        = 8;
    localparam int LANES       = 4;
    localparam int NUM_WEIGHTS = 8;
    localparam int HIST_LEN    = TAPS - 1;
    localparam int WIN_LEN     = HIST_LEN + LANES;
    localparam int DATA_W      = 16;
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int PAIRS       = (TAPS + 1) / 2;
    localparam int MAC_N       = 2 * PAIRS;
    localparam int WIN_PAD     = LANES - 1 + MAC_N;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + $clog2(MAC_N);
    localparam int CFG_IDX_W   = 4;
    localparam int WIDX_W      = $clog2(NUM_WEIGHTS);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]  lane_sum_t;

    typedef struct packed {
        sample_t sample_a;
        sample_t sample_b;
        sample_t sample_c;
        sample_t sample_d;
        logic    block_end;
    } in_item_t;

    typedef struct packed {
        sample_t filtered_a;
        sample_t filtered_b;
        sample_t filtered_c;
        sample_t filtered_d;
        logic    clipped;
        logic    block_end_out;
    } out_item_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } stage_ctrl_t;

endpackage

[hdl/fir4_lane.sv]
`timescale 1ns / 1ps

module fir4_lane (
    input  logic                    clk,
    input  fir4_pkg::stage_ctrl_t   ctrl,
    input  fir4_pkg::sample_t       window [fir4_pkg::MAC_N],
    input  fir4_pkg::sample_t       weights [fir4_pkg::MAC_N],
    output fir4_pkg::lane_sum_t     sum
);

    logic signed [fir4_pkg::PROD_W-1:0] prod_reg [fir4_pkg::MAC_N];
    logic signed [fir4_pkg::PROD_W-1:0] prod_next [fir4_pkg::MAC_N];
    logic signed [fir4_pkg::PAIR_W-1:0] pair_reg [fir4_pkg::PAIRS];
    logic signed [fir4_pkg::PAIR_W-1:0] pair_next [fir4_pkg::PAIRS];
    fir4_pkg::lane_sum_t                sum_reg;
    fir4_pkg::lane_sum_t                sum_next;

    always_comb
    begin
        for (int j = 0; j < fir4_pkg::MAC_N; j++)
        begin
            prod_next[j] = fir4_pkg::PROD_W'(window[j] * weights[j]);
        end
    end

    always_comb
    begin
        for (int p = 0; p < fir4_pkg::PAIRS; p++)
        begin
            pair_next[p] = fir4_pkg::PAIR_W'(prod_reg[2*p])
                         + fir4_pkg::PAIR_W'(prod_reg[2*p+1]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int p = 0; p < fir4_pkg::PAIRS; p++)
        begin
            sum_next = sum_next + fir4_pkg::SUM_W'(pair_reg[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.en2)
        begin
            pair_reg <= pair_next;
        end
        if (ctrl.en3)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

[hdl/fir4_merge.sv]
`timescale 1ns / 1ps

module fir4_merge (
    input  fir4_pkg::lane_sum_t   sums [fir4_pkg::LANES],
    input  logic                  block_end,
    output fir4_pkg::out_item_t   result
);

    localparam int Q_W = fir4_pkg::SUM_W + 1 - fir4_pkg::FRAC_W;

    logic signed [fir4_pkg::SUM_W:0]     biased [fir4_pkg::LANES];
    logic signed [Q_W-1:0]               quot [fir4_pkg::LANES];
    logic [Q_W-fir4_pkg::DATA_W:0]       upper [fir4_pkg::LANES];
    logic [fir4_pkg::LANES-1:0]          sat;
    fir4_pkg::sample_t                   value [fir4_pkg::LANES];

    always_comb
    begin
        for (int k = 0; k < fir4_pkg::LANES; k++)
        begin
            biased[k] = (fir4_pkg::SUM_W+1)'(sums[k])
                      + (fir4_pkg::SUM_W+1)'(1 << (fir4_pkg::FRAC_W - 1));
            quot[k]   = Q_W'(biased[k] >>> fir4_pkg::FRAC_W);
            upper[k]  = quot[k][Q_W-1:fir4_pkg::DATA_W-1];
            sat[k]    = (|upper[k]) && !(&upper[k]);
            if (sat[k])
            begin
                value[k] = quot[k][Q_W-1] ? {1'b1, {(fir4_pkg::DATA_W-1){1'b0}}}
                                          : {1'b0, {(fir4_pkg::DATA_W-1){1'b1}}};
            end
            else
            begin
                value[k] = quot[k][fir4_pkg::DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        result.filtered_a    = value[0];
        result.filtered_b    = value[1];
        result.filtered_c    = value[2];
        result.filtered_d    = value[3];
        result.clipped       = |sat;
        result.block_end_out = block_end;
    end

endmodule

[hdl/fir_filter_four_lane.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  sample_item (four samples, block_end)
// result    out        result_valid/result_ready  result_item (four outputs, flags)
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data (tap weights)
//
// One sample transaction is accepted per clock unless a stalled result backs up the pipeline;
// each result passes the product, pair-sum, total-sum and round/saturate registers in turn.
// Reset clears the weights, the sample history and all pipeline valid flags.
// A stalled result only holds back stages behind it that are full; bubbles still fill.
// Configuration writes are always accepted.

module fir_filter_four_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  fir4_pkg::in_item_t                    sample_item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output fir4_pkg::out_item_t                   result_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fir4_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  fir4_pkg::sample_t                     cfg_data
);

    fir4_pkg::sample_t     weight_reg [fir4_pkg::NUM_WEIGHTS];
    fir4_pkg::sample_t     hist_reg [fir4_pkg::HIST_LEN];
    fir4_pkg::sample_t     hist_next [fir4_pkg::HIST_LEN];
    fir4_pkg::sample_t     new_samples [fir4_pkg::LANES];
    fir4_pkg::sample_t     win_pad [fir4_pkg::WIN_PAD];
    fir4_pkg::sample_t     weight_pad [fir4_pkg::MAC_N];
    fir4_pkg::sample_t     lane_win [fir4_pkg::LANES][fir4_pkg::MAC_N];
    fir4_pkg::lane_sum_t   lane_sums [fir4_pkg::LANES];
    fir4_pkg::out_item_t   merged;
    fir4_pkg::out_item_t   result_reg;
    fir4_pkg::stage_ctrl_t ctrl;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic result_valid_reg;
    logic end1_reg;
    logic end2_reg;
    logic end3_reg;
    logic en_out;
    logic en1;
    logic en2;
    logic en3;
    logic in_fire;
    logic cfg_fire;

    assign en_out       = !result_valid_reg || result_ready;
    assign en3          = !v3_reg || en_out;
    assign en2          = !v2_reg || en3;
    assign en1          = !v1_reg || en2;
    assign ctrl.en1     = en1;
    assign ctrl.en2     = en2;
    assign ctrl.en3     = en3;
    assign sample_ready = en1;
    assign in_fire      = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    assign cfg_fire     = cfg_valid && cfg_ready;

    always_comb
    begin
        new_samples[0] = sample_item.sample_a;
        new_samples[1] = sample_item.sample_b;
        new_samples[2] = sample_item.sample_c;
        new_samples[3] = sample_item.sample_d;
    end

    always_comb
    begin
        for (int i = 0; i < fir4_pkg::WIN_PAD; i++)
        begin
            if (i < fir4_pkg::HIST_LEN)
            begin
                win_pad[i] = hist_reg[i];
            end
            else if (i < fir4_pkg::WIN_LEN)
            begin
                win_pad[i] = new_samples[i - fir4_pkg::HIST_LEN];
            end
            else
            begin
                win_pad[i] = '0;
            end
        end
        for (int i = 0; i < fir4_pkg::HIST_LEN; i++)
        begin
            hist_next[i] = win_pad[fir4_pkg::LANES + i];
        end
        for (int j = 0; j < fir4_pkg::MAC_N; j++)
        begin
            weight_pad[j] = (j < fir4_pkg::TAPS) ? weight_reg[j] : '0;
        end
        for (int k = 0; k < fir4_pkg::LANES; k++)
        begin
            for (int j = 0; j < fir4_pkg::MAC_N; j++)
            begin
                lane_win[k][j] = win_pad[k + j];
            end
        end
    end

    for (genvar k = 0; k < fir4_pkg::LANES; k++)
    begin : g_lane
        fir4_lane u_lane (
            .clk     (clk),
            .ctrl    (ctrl),
            .window  (lane_win[k]),
            .weights (weight_pad),
            .sum     (lane_sums[k])
        );
    end

    fir4_merge u_merge (
        .sums      (lane_sums),
        .block_end (end3_reg),
        .result    (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fir4_pkg::NUM_WEIGHTS; i++)
            begin
                weight_reg[i] <= '0;
            end
            for (int i = 0; i < fir4_pkg::HIST_LEN; i++)
            begin
                hist_reg[i] <= '0;
            end
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire && (cfg_index < fir4_pkg::CFG_IDX_W'(fir4_pkg::NUM_WEIGHTS)))
            begin
                weight_reg[cfg_index[fir4_pkg::WIDX_W-1:0]] <= cfg_data;
            end
            if (in_fire)
            begin
                hist_reg <= hist_next;
            end
            if (ctrl.en1)
            begin
                v1_reg <= sample_valid;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_out)
            begin
                result_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            end1_reg <= sample_item.block_end;
        end
        if (ctrl.en2)
        begin
            end2_reg <= end1_reg;
        end
        if (ctrl.en3)
        begin
            end3_reg <= end2_reg;
        end
        if (en_out)
        begin
            result_reg <= merged;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

`ifndef SYNTHESIS
    // An accepted transaction always lands in the first stage.
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> v1_reg)
        else $error("accepted sample transaction lost at stage one");

    // The input is only held off when the first stage is occupied.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> v1_reg)
        else $error("sample channel stalled with an empty first stage");

    // A finished sum that moves on must become a visible result.
    a_sum_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && en_out) |=> result_valid)
        else $error("completed sum did not reach the result register");

    // A weight write takes effect in the addressed register.
    a_weight_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && (cfg_index < fir4_pkg::CFG_IDX_W'(fir4_pkg::NUM_WEIGHTS)))
        |=> (weight_reg[$past(cfg_index[fir4_pkg::WIDX_W-1:0])] == $past(cfg_data)))
        else $error("weight write not stored");
`endif

endmodule
